### rtl/core/rlpl_pkg.sv
// shared types and constants for the run-length position-to-line table
package rlpl_pkg;

    localparam int MAX_RUNS  = 256;
    localparam int MAX_BYTES = 65536;

    localparam int LINE_W = 16;
    localparam int POS_W  = 16;
    localparam int ADDR_W = $clog2(MAX_RUNS);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int END_W  = $clog2(MAX_BYTES) + 1;

    localparam logic [CNT_W-1:0] MAX_RUNS_C  = CNT_W'(MAX_RUNS);
    localparam logic [END_W-1:0] MAX_BYTES_C = END_W'(MAX_BYTES);

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              we_end;
        logic              we_line;
        logic [ADDR_W-1:0] addr;
        logic [END_W-1:0]  end_off;
        logic [LINE_W-1:0] line;
    } mem_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } mem_rd_t;

endpackage

### rtl/core/rlpl_store.sv
// run table storage: end offsets and line numbers, one write and one registered read port
module rlpl_store (
    input  logic                       clk,
    input  rlpl_pkg::mem_wr_t          wr,
    input  rlpl_pkg::mem_rd_t          rd,
    output logic [rlpl_pkg::END_W-1:0] rd_end,
    output logic [rlpl_pkg::LINE_W-1:0] rd_line
);

    logic [rlpl_pkg::END_W-1:0]  run_end_mem  [rlpl_pkg::MAX_RUNS];
    logic [rlpl_pkg::LINE_W-1:0] run_line_mem [rlpl_pkg::MAX_RUNS];

    always_ff @(posedge clk)
    begin
        if (wr.we_end)
        begin
            run_end_mem[wr.addr] <= wr.end_off;
        end
        if (wr.we_line)
        begin
            run_line_mem[wr.addr] <= wr.line;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_end  <= run_end_mem[rd.addr];
            rd_line <= run_line_mem[rd.addr];
        end
    end

endmodule

### rtl/core/rlpl_ctrl.sv
// sequencer: append update, binary search over the run table, result register
module rlpl_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        op,
    input  logic [rlpl_pkg::LINE_W-1:0] line,
    input  logic [rlpl_pkg::POS_W-1:0]  position,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rlpl_pkg::LINE_W-1:0] found_line,
    output logic [1:0]                  status,
    output rlpl_pkg::mem_wr_t           wr,
    output rlpl_pkg::mem_rd_t           rd,
    input  logic [rlpl_pkg::END_W-1:0]  rd_end,
    input  logic [rlpl_pkg::LINE_W-1:0] rd_line
);

    rlpl_pkg::state_t state_reg, state_next;

    logic [rlpl_pkg::CNT_W-1:0]  run_count_reg, run_count_next;
    logic [rlpl_pkg::LINE_W-1:0] top_line_reg, top_line_next;
    logic [rlpl_pkg::END_W-1:0]  total_reg, total_next;
    logic                        out_valid_reg, out_valid_next;

    logic [rlpl_pkg::CNT_W-1:0]  lo_reg, lo_next;
    logic [rlpl_pkg::CNT_W-1:0]  hi_reg, hi_next;
    logic [rlpl_pkg::CNT_W-1:0]  mid_reg, mid_next;
    logic [rlpl_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                        hit_reg, hit_next;
    logic [rlpl_pkg::LINE_W-1:0] res_line_reg, res_line_next;
    rlpl_pkg::status_t           res_status_reg, res_status_next;
    logic [rlpl_pkg::LINE_W-1:0] found_line_reg, found_line_next;
    rlpl_pkg::status_t           status_reg, status_next;

    logic                        open_new;
    logic [rlpl_pkg::CNT_W:0]    mid_sum;
    logic [rlpl_pkg::CNT_W-1:0]  mid;

    assign open_new = (run_count_reg == '0) || (line > top_line_reg);
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[rlpl_pkg::CNT_W:1];

    always_comb
    begin
        state_next      = state_reg;
        run_count_next  = run_count_reg;
        top_line_next   = top_line_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        pos_next        = pos_reg;
        hit_next        = hit_reg;
        res_line_next   = res_line_reg;
        res_status_next = res_status_reg;
        found_line_next = found_line_reg;
        status_next     = status_reg;
        wr              = '0;
        rd              = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            rlpl_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    res_line_next = '0;
                    state_next    = rlpl_pkg::S_DONE;
                    if (op == rlpl_pkg::OP_APPEND)
                    begin
                        if (total_reg >= rlpl_pkg::MAX_BYTES_C)
                        begin
                            res_status_next = rlpl_pkg::ST_OVERFLOW;
                        end
                        else if (open_new && (run_count_reg >= rlpl_pkg::MAX_RUNS_C))
                        begin
                            res_status_next = rlpl_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            res_status_next = rlpl_pkg::ST_OK;
                            wr.we_end       = 1'b1;
                            wr.we_line      = open_new;
                            wr.end_off      = total_reg + rlpl_pkg::END_W'(1);
                            wr.line         = line;
                            total_next      = total_reg + rlpl_pkg::END_W'(1);
                            if (open_new)
                            begin
                                wr.addr        = run_count_reg[rlpl_pkg::ADDR_W-1:0];
                                run_count_next = run_count_reg + rlpl_pkg::CNT_W'(1);
                                top_line_next  = line;
                            end
                            else
                            begin
                                wr.addr = rlpl_pkg::ADDR_W'(run_count_reg
                                                            - rlpl_pkg::CNT_W'(1));
                            end
                        end
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = run_count_reg;
                        pos_next   = position;
                        hit_next   = 1'b0;
                        state_next = rlpl_pkg::S_PROBE;
                    end
                end
            end

            rlpl_pkg::S_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd.en      = 1'b1;
                    rd.addr    = mid[rlpl_pkg::ADDR_W-1:0];
                    mid_next   = mid;
                    state_next = rlpl_pkg::S_CMP;
                end
                else
                begin
                    res_status_next = hit_reg ? rlpl_pkg::ST_OK : rlpl_pkg::ST_NOT_FOUND;
                    state_next      = rlpl_pkg::S_DONE;
                end
            end

            rlpl_pkg::S_CMP:
            begin
                if (rd_end > {1'b0, pos_reg})
                begin
                    hi_next       = mid_reg;
                    hit_next      = 1'b1;
                    res_line_next = rd_line;
                end
                else
                begin
                    lo_next = mid_reg + rlpl_pkg::CNT_W'(1);
                end
                state_next = rlpl_pkg::S_PROBE;
            end

            rlpl_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    found_line_next = res_line_reg;
                    status_next     = res_status_reg;
                    state_next      = rlpl_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = rlpl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rlpl_pkg::S_IDLE;
            run_count_reg <= '0;
            top_line_reg  <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_count_reg <= run_count_next;
            top_line_reg  <= top_line_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        pos_reg        <= pos_next;
        hit_reg        <= hit_next;
        res_line_reg   <= res_line_next;
        res_status_reg <= res_status_next;
        found_line_reg <= found_line_next;
        status_reg     <= status_next;
    end

    assign in_ready   = (state_reg == rlpl_pkg::S_IDLE);
    assign out_valid  = out_valid_reg;
    assign found_line = found_line_reg;
    assign status     = status_reg;

endmodule

### rtl/core/run_length_position_to_line_table_unit.sv
// top level of the run-length position-to-line table
// append: the beat writes the run table; the next beat waits until the result is registered
// lookup: each binary-search probe is a memory read, then a compare, with up to
//   log2(run count)+1 probes
// in_ready returns with the result; the output register frees the search while a result waits
// reset clears run count, top line and byte total; the run memories need no clearing
module run_length_position_to_line_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [15:0] line,
    input  logic [15:0] position,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] found_line,
    output logic [1:0]  status
);

    rlpl_pkg::mem_wr_t                   wr;
    rlpl_pkg::mem_rd_t                   rd;
    logic [rlpl_pkg::END_W-1:0]          rd_end;
    logic [rlpl_pkg::LINE_W-1:0]         rd_line;

    rlpl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .line       (line),
        .position   (position),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found_line (found_line),
        .status     (status),
        .wr         (wr),
        .rd         (rd),
        .rd_end     (rd_end),
        .rd_line    (rd_line)
    );

    rlpl_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_end  (rd_end),
        .rd_line (rd_line)
    );

    // one item at a time
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in work");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == rlpl_pkg::ST_OK || status == rlpl_pkg::ST_NOT_FOUND
                       || status == rlpl_pkg::ST_OVERFLOW))
        else $error("illegal status code");

    a_line_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != rlpl_pkg::ST_OK) |-> (found_line == '0))
        else $error("line reported on a failed beat");

    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd.en && (wr.we_end || wr.we_line)))
        else $error("table written during a search");

endmodule
